FILE: rtl/core/png_scanline_unfilter_core_macros.svh
// Assertion macros used by the checker of the scanline unfilter core.
`ifndef PNG_SCANLINE_UNFILTER_CORE_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PUS_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PUS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pus_pkg.sv
// Types, codes and the Paeth predictor shared by the scanline unfilter core.
package pus_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int PIX_SEL_W   = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_INDEX_W-1:0] CFG_BPP       = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_BYTES = 2'd1;

  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  typedef enum logic [1:0] {
    KIND_ROW_START,
    KIND_DATA,
    KIND_ERROR
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [7:0]           data;
    logic [2:0]           filter;
    logic                 first_row;
    logic                 have_left;
    logic [PIX_SEL_W-1:0] bpp_m1;
    logic                 row_end;
  } item_t;

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [10:0] da;
    logic signed [10:0] db;
    logic signed [10:0] dc;
    logic [9:0]         pa;
    logic [9:0]         pb;
    logic [9:0]         pc;
    da = $signed({3'b000, b}) - $signed({3'b000, c});
    db = $signed({3'b000, a}) - $signed({3'b000, c});
    dc = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
    pa = da[10] ? 10'(-da) : 10'(da);
    pb = db[10] ? 10'(-db) : 10'(db);
    pc = dc[10] ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end else begin
      return c;
    end
  endfunction

endpackage

FILE: rtl/core/png_scanline_unfilter_core.sv
// Top level of the PNG scanline unfilter core.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   in      | input     | in_valid / in_ready  | in_byte, image_start
//   out     | output    | out_valid / out_ready| out_byte, row_end, bad_filter
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item is accepted per cycle while the queue is not full; results leave at one per cycle
// while out_ready is high, through the queue, the prior row read and the output register.
// Reset clears row tracking, the queue, histories and the output valid flag.
// The prior row memory is not cleared and needs no clearing pass.
// A stalled output holds its result while the four-item queue keeps taking input.
// Configuration writes are always accepted.
module png_scanline_unfilter_core #(
  parameter int MAX_ROW_BYTES   = 16384,
  parameter int MAX_PIXEL_BYTES = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_byte,
  input  logic                            image_start,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_byte,
  output logic                            row_end,
  output logic                            bad_filter,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pus_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [14:0]                     cfg_data
);

  localparam int COL_W = $clog2(MAX_ROW_BYTES);
  localparam int ENTRY_W = $bits(pus_pkg::item_t) + COL_W;

  logic               q_full;
  logic               push;
  pus_pkg::item_t     push_item;
  logic [COL_W-1:0]   push_col;
  logic               pop;
  logic               q_valid;
  logic [ENTRY_W-1:0] q_data;
  pus_pkg::item_t     q_item;
  logic [COL_W-1:0]   q_col;

  assign q_item = pus_pkg::item_t'(q_data[ENTRY_W-1:COL_W]);
  assign q_col  = q_data[COL_W-1:0];

  pus_front #(
    .MAX_ROW_BYTES   (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .image_start (image_start),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_full      (q_full),
    .push        (push),
    .push_item   (push_item),
    .push_col    (push_col)
  );

  pus_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (pus_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_item, push_col}),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  pus_back #(
    .MAX_ROW_BYTES   (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_col      (q_col),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .row_end    (row_end),
    .bad_filter (bad_filter)
  );

endmodule

FILE: rtl/core/pus_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pus_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/pus_front.sv
// Front end: configuration registers, row tracking and item classification.
module pus_front #(
  parameter int MAX_ROW_BYTES   = 16384,
  parameter int MAX_PIXEL_BYTES = 8,
  localparam int COL_W = $clog2(MAX_ROW_BYTES),
  localparam int CNT_W = $clog2(MAX_ROW_BYTES + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_byte,
  input  logic                          image_start,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pus_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [14:0]                   cfg_data,
  input  logic                          q_full,
  output logic                          push,
  output pus_pkg::item_t                push_item,
  output logic [COL_W-1:0]              push_col
);

  logic [3:0]       bytes_per_pixel;
  logic [14:0]      row_bytes;
  logic [CNT_W-1:0] column_count;
  logic [CNT_W-1:0] column_count_next;
  logic [2:0]       row_filter;
  logic [2:0]       row_filter_next;
  logic             on_first_row;
  logic             on_first_row_next;
  logic             halted;
  logic             halted_next;

  logic             accept;
  logic [CNT_W-1:0] cnt_cur;
  logic [CNT_W-1:0] cnt_m1;
  logic             first_cur;
  logic             halt_cur;
  logic [CNT_W-1:0] rb_eff;
  logic [3:0]       bpp_eff;
  logic             row_end_now;

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !q_full;

  assign cnt_cur   = image_start ? '0 : column_count;
  assign first_cur = image_start ? 1'b1 : on_first_row;
  assign halt_cur  = image_start ? 1'b0 : halted;
  assign cnt_m1    = cnt_cur - CNT_W'(1);
  assign push_col  = cnt_m1[COL_W-1:0];

  always_comb begin
    if (row_bytes == '0) begin
      rb_eff = CNT_W'(1);
    end else if (int'(row_bytes) > MAX_ROW_BYTES) begin
      rb_eff = CNT_W'(MAX_ROW_BYTES);
    end else begin
      rb_eff = CNT_W'(row_bytes);
    end
    if (bytes_per_pixel == '0) begin
      bpp_eff = 4'd1;
    end else if (int'(bytes_per_pixel) > MAX_PIXEL_BYTES) begin
      bpp_eff = 4'(MAX_PIXEL_BYTES);
    end else begin
      bpp_eff = bytes_per_pixel;
    end
  end

  assign row_end_now = cnt_cur >= rb_eff;

  always_comb begin
    column_count_next = column_count;
    row_filter_next   = row_filter;
    on_first_row_next = on_first_row;
    halted_next       = halted;
    push              = 1'b0;
    push_item.kind      = pus_pkg::KIND_DATA;
    push_item.data      = in_byte;
    push_item.filter    = row_filter;
    push_item.first_row = first_cur;
    push_item.have_left = int'(push_col) >= int'(bpp_eff);
    push_item.bpp_m1    = pus_pkg::PIX_SEL_W'(bpp_eff - 4'd1);
    push_item.row_end   = row_end_now;
    if (accept) begin
      column_count_next = cnt_cur;
      on_first_row_next = first_cur;
      halted_next       = halt_cur;
      if (!halt_cur) begin
        push = 1'b1;
        if (cnt_cur == '0) begin
          if (in_byte > {5'd0, pus_pkg::FILT_PAETH}) begin
            push_item.kind = pus_pkg::KIND_ERROR;
            halted_next    = 1'b1;
          end else begin
            push_item.kind    = pus_pkg::KIND_ROW_START;
            row_filter_next   = in_byte[2:0];
            column_count_next = CNT_W'(1);
          end
        end else if (row_end_now) begin
          column_count_next = '0;
          on_first_row_next = 1'b0;
        end else begin
          column_count_next = cnt_cur + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= 4'd1;
      row_bytes       <= 15'd4;
      column_count    <= '0;
      row_filter      <= pus_pkg::FILT_NONE;
      on_first_row    <= 1'b1;
      halted          <= 1'b0;
    end else begin
      column_count <= column_count_next;
      row_filter   <= row_filter_next;
      on_first_row <= on_first_row_next;
      halted       <= halted_next;
      if (cfg_valid) begin
        case (cfg_index)
          pus_pkg::CFG_BPP:       bytes_per_pixel <= cfg_data[3:0];
          pus_pkg::CFG_ROW_BYTES: row_bytes       <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: rtl/core/pus_queue.sv
// Short FIFO that decouples the front end from the reconstruction back end.
module pus_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output logic [WIDTH-1:0] q_data
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full    = count == CW'(DEPTH);
  assign q_valid = count != '0;
  assign q_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (int'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (int'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/core/pus_back.sv
// Back end: prior row memory, neighbor histories, predictors and output register.
module pus_back #(
  parameter int MAX_ROW_BYTES   = 16384,
  parameter int MAX_PIXEL_BYTES = 8,
  localparam int COL_W = $clog2(MAX_ROW_BYTES),
  localparam int PIX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  pus_pkg::item_t   q_item,
  input  logic [COL_W-1:0] q_col,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             row_end,
  output logic             bad_filter
);

  logic             b2_valid;
  pus_pkg::item_t   b2_item;
  logic [COL_W-1:0] b2_col;
  logic [7:0]       up_rd;
  logic [7:0]       left_hist [MAX_PIXEL_BYTES];
  logic [7:0]       upleft_hist [MAX_PIXEL_BYTES];

  logic             out_free;
  logic             b2_move;
  logic             consume;
  logic             wr_en;
  logic [PIX_W-1:0] sel;
  logic [7:0]       a;
  logic [7:0]       b;
  logic [7:0]       c;
  logic [8:0]       sum_ab;
  logic [7:0]       pred;
  logic [7:0]       recon;

  assign out_free = !out_valid || out_ready;
  assign b2_move  = !b2_valid || out_free;
  assign pop      = b2_move && q_valid;
  assign consume  = b2_move && b2_valid;
  assign wr_en    = consume && b2_item.kind == pus_pkg::KIND_DATA;

  assign sel    = b2_item.bpp_m1[PIX_W-1:0];
  assign a      = b2_item.have_left ? left_hist[sel] : 8'd0;
  assign b      = b2_item.first_row ? 8'd0 : up_rd;
  assign c      = (b2_item.have_left && !b2_item.first_row) ? upleft_hist[sel] : 8'd0;
  assign sum_ab = {1'b0, a} + {1'b0, b};

  always_comb begin
    case (b2_item.filter)
      pus_pkg::FILT_SUB:   pred = a;
      pus_pkg::FILT_UP:    pred = b;
      pus_pkg::FILT_AVG:   pred = sum_ab[8:1];
      pus_pkg::FILT_PAETH: pred = pus_pkg::paeth(a, b, c);
      default:             pred = 8'd0;
    endcase
  end

  assign recon = b2_item.data + pred;

  pus_ram #(
    .WIDTH (8),
    .DEPTH (MAX_ROW_BYTES)
  ) u_prior_row (
    .clk   (clk),
    .we    (wr_en),
    .waddr (b2_col),
    .wdata (recon),
    .re    (pop),
    .raddr (q_col),
    .rdata (up_rd)
  );

  always_ff @(posedge clk) begin
    if (b2_move) begin
      b2_item <= q_item;
      b2_col  <= q_col;
    end
    if (consume && b2_item.kind == pus_pkg::KIND_DATA) begin
      out_byte   <= recon;
      row_end    <= b2_item.row_end;
      bad_filter <= 1'b0;
    end else if (consume && b2_item.kind == pus_pkg::KIND_ERROR) begin
      out_byte   <= 8'd0;
      row_end    <= 1'b0;
      bad_filter <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b2_valid  <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_hist[i]   <= 8'd0;
        upleft_hist[i] <= 8'd0;
      end
    end else begin
      if (b2_move) begin
        b2_valid <= q_valid;
      end
      if (consume && b2_item.kind != pus_pkg::KIND_ROW_START) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (consume && b2_item.kind == pus_pkg::KIND_ROW_START) begin
        for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
          left_hist[i]   <= 8'd0;
          upleft_hist[i] <= 8'd0;
        end
      end else if (wr_en) begin
        left_hist[0]   <= recon;
        upleft_hist[0] <= b;
        for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
          left_hist[i]   <= left_hist[i-1];
          upleft_hist[i] <= upleft_hist[i-1];
        end
      end
    end
  end

endmodule

FILE: rtl/core/pus_checker.sv
// Port-level checker for the scanline unfilter core, bound to the top level.
`include "png_scanline_unfilter_core_macros.svh"

module pus_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       row_end,
  input logic       bad_filter
);

  `PUS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(row_end) && $stable(bad_filter), "Stalled result changed.")
  `PUS_ASSERT_IMP(a_error_shape, clk, rst, out_valid && bad_filter, out_byte == 8'd0 && !row_end, "Error result carries data or a row end.")
  `PUS_ASSERT_IMP(a_reset_quiet, clk, rst, $past(rst), !out_valid, "Result shown right after reset.")

endmodule

bind png_scanline_unfilter_core pus_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_byte   (out_byte),
  .row_end    (row_end),
  .bad_filter (bad_filter)
);

FILE: test/tb_png_scanline_unfilter_core.sv
// Self-checking testbench for the PNG scanline unfilter core.
`timescale 1ns / 100ps

module tb_png_scanline_unfilter_core;

  localparam int ROW_LIMIT   = 16384;
  localparam int PIXEL_LIMIT = 8;

  localparam logic [pus_pkg::CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [pus_pkg::CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [7:0] pix;
    logic       row_last;
    logic       bad;
  } result_t;

  logic                            clk         = 1'b0;
  logic                            rst         = 1'b1;
  logic                            in_valid    = 1'b0;
  logic                            in_ready;
  logic [7:0]                      in_byte     = 8'h00;
  logic                            image_start = 1'b0;
  logic                            out_valid;
  logic                            out_ready   = 1'b0;
  logic [7:0]                      out_byte;
  logic                            row_end;
  logic                            bad_filter;
  logic                            cfg_valid   = 1'b0;
  logic                            cfg_ready;
  logic [pus_pkg::CFG_INDEX_W-1:0] cfg_index   = pus_pkg::CFG_BPP;
  logic [14:0]                     cfg_data    = 15'd0;

  png_scanline_unfilter_core #(
    .MAX_ROW_BYTES  (ROW_LIMIT),
    .MAX_PIXEL_BYTES(PIXEL_LIMIT)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .image_start(image_start),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .row_end    (row_end),
    .bad_filter (bad_filter),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // Shadow of the unfilter state, updated for every accepted item.
  logic [7:0]  prior_mem [0:ROW_LIMIT-1];
  int unsigned prior_len  = 0;
  logic [63:0] left_hist  = 64'd0;
  logic [63:0] up_hist    = 64'd0;
  int unsigned col_cnt    = 0;
  logic [2:0]  cur_filter = pus_pkg::FILT_NONE;
  bit          first_row  = 1'b1;
  bit          stopped    = 1'b0;
  logic [3:0]  cfg_bpp    = 4'd1;
  logic [14:0] cfg_rb     = 15'd4;

  result_t pixel_q[$];
  int      work_items  = 0;
  int      miss_count  = 0;
  int      out_seen    = 0;
  int      gap_max     = 3;
  int      burst_left  = 0;
  bit      rx_stalls   = 1'b1;

  logic [15:0] ready_pat = 16'hFFFF;
  int          ready_cnt = 0;
  result_t     got_r;
  result_t     want_r;

  always @(posedge clk) begin
    if (ready_cnt == 0) begin
      ready_cnt <= $urandom_range(32, 300);
      if (!rx_stalls || $urandom_range(0, 3) == 0) begin
        ready_pat <= 16'hFFFF;
      end else begin
        ready_pat <= 16'($urandom) | 16'h1111;
      end
    end else begin
      ready_cnt <= ready_cnt - 1;
      ready_pat <= {ready_pat[0], ready_pat[15:1]};
    end
    out_ready <= ready_pat[0];
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_r = '{pix: out_byte, row_last: row_end, bad: bad_filter};
      if (pixel_q.size() == 0) begin
        miss_count++;
        if (miss_count <= 10) begin
          $display("unexpected result %0d: byte %02h row_end %0b bad_filter %0b",
                   out_seen, got_r.pix, got_r.row_last, got_r.bad);
        end
      end else begin
        want_r = pixel_q.pop_front();
        if (got_r.pix !== want_r.pix || got_r.row_last !== want_r.row_last ||
            got_r.bad !== want_r.bad) begin
          miss_count++;
          if (miss_count <= 10) begin
            $display("result %0d: expected byte %02h row_end %0b bad_filter %0b, got %02h %0b %0b",
                     out_seen, want_r.pix, want_r.row_last, want_r.bad,
                     got_r.pix, got_r.row_last, got_r.bad);
          end
        end
      end
      out_seen++;
    end
  end

  initial begin
    #(20_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [7:0] pick_paeth(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    int est;
    int da;
    int db;
    int dc;
    est = int'(a) + int'(b) - int'(c);
    da = est > int'(a) ? est - int'(a) : int'(a) - est;
    db = est > int'(b) ? est - int'(b) : int'(b) - est;
    dc = est > int'(c) ? est - int'(c) : int'(c) - est;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  // Returns 1 when the item is not ignored by a halted block.
  function automatic bit rebuild_byte(input logic [7:0] x, input logic img);
    int unsigned bpp;
    int unsigned rb;
    int unsigned col;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [7:0]  pred;
    logic [7:0]  r;
    bit          left_ok;
    result_t     res;
    if (img) begin
      col_cnt   = 0;
      left_hist = 64'd0;
      up_hist   = 64'd0;
      first_row = 1'b1;
      stopped   = 1'b0;
    end
    if (stopped) return 1'b0;
    bpp = (cfg_bpp == 0) ? 1 : (cfg_bpp > PIXEL_LIMIT ? PIXEL_LIMIT : cfg_bpp);
    rb  = (cfg_rb == 0) ? 1 : (cfg_rb > ROW_LIMIT ? ROW_LIMIT : cfg_rb);
    if (col_cnt == 0) begin
      if (x > 8'(pus_pkg::FILT_PAETH)) begin
        stopped = 1'b1;
        res = '{pix: 8'h00, row_last: 1'b0, bad: 1'b1};
        pixel_q.push_back(res);
        return 1'b1;
      end
      cur_filter = x[2:0];
      col_cnt    = 1;
      return 1'b1;
    end
    col = col_cnt - 1;
    if (col >= ROW_LIMIT) col = ROW_LIMIT - 1;
    left_ok = col >= bpp;
    a = left_ok ? left_hist[8*(bpp-1) +: 8] : 8'h00;
    b = first_row ? 8'h00 : prior_mem[col];
    c = (left_ok && !first_row) ? up_hist[8*(bpp-1) +: 8] : 8'h00;
    case (cur_filter)
      pus_pkg::FILT_SUB:   pred = a;
      pus_pkg::FILT_UP:    pred = b;
      pus_pkg::FILT_AVG:   pred = 8'((9'(a) + 9'(b)) >> 1);
      pus_pkg::FILT_PAETH: pred = pick_paeth(a, b, c);
      default:             pred = 8'h00;
    endcase
    r = x + pred;
    prior_mem[col] = r;
    if (col + 1 > prior_len) prior_len = col + 1;
    left_hist = {left_hist[55:0], r};
    up_hist   = {up_hist[55:0], b};
    res = '{pix: r, row_last: col_cnt >= rb, bad: 1'b0};
    pixel_q.push_back(res);
    if (col_cnt >= rb) begin
      col_cnt   = 0;
      left_hist = 64'd0;
      up_hist   = 64'd0;
      first_row = 1'b0;
    end else begin
      col_cnt++;
    end
    return 1'b1;
  endfunction

  // True when a data item would read a prior row entry that was never written.
  function automatic bit reads_unwritten(input logic img);
    int unsigned col;
    if (img || stopped || col_cnt == 0 || first_row) return 1'b0;
    col = col_cnt - 1;
    if (col >= ROW_LIMIT) col = ROW_LIMIT - 1;
    return col >= prior_len;
  endfunction

  task automatic feed_byte(input logic [7:0] x, input logic img);
    int  gap;
    logic start_bit;
    gap = 0;
    start_bit = img;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if (gap_max > 0) gap = $urandom_range(0, gap_max);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    if (reads_unwritten(start_bit)) start_bit = 1'b1;
    in_valid    <= 1'b1;
    in_byte     <= x;
    image_start <= start_bit;
    do @(posedge clk); while (!in_ready);
    if (rebuild_byte(x, start_bit)) work_items++;
  endtask

  task automatic feed_random_bytes(input int count);
    for (int n = 0; n < count; n++) begin
      feed_byte(8'($urandom), 1'b0);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [pus_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [14:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      pus_pkg::CFG_BPP:       cfg_bpp = val[3:0];
      pus_pkg::CFG_ROW_BYTES: cfg_rb  = val;
      default:                ;
    endcase
  endtask

  task automatic set_config(input logic [14:0] bpp_word, input logic [14:0] rb_word,
                            input bit spare);
    if (spare) cfg_write($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 15'($urandom));
    cfg_write(pus_pkg::CFG_BPP, bpp_word);
    cfg_write(pus_pkg::CFG_ROW_BYTES, rb_word);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [14:0] pick_bpp_word();
    logic [3:0] bpp;
    bpp = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(1, PIXEL_LIMIT)) : 4'($urandom);
    return {($urandom_range(0, 3) == 0) ? 11'($urandom) : 11'd0, bpp};
  endfunction

  function automatic logic [14:0] pick_rb_word();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 15'd0;
    if (pick == 1) return 15'($urandom_range(100, 400));
    return 15'($urandom_range(1, 24));
  endfunction

  function automatic logic [7:0] pick_filter();
    if ($urandom_range(0, 9) == 0) begin
      return 8'($urandom_range(int'(pus_pkg::FILT_PAETH) + 1, 255));
    end
    return 8'($urandom_range(int'(pus_pkg::FILT_NONE), int'(pus_pkg::FILT_PAETH)));
  endfunction

  function automatic logic [7:0] pick_data();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic test_every_filter();
    feed_byte(8'(pus_pkg::FILT_NONE), 1'b1);
    feed_byte(8'h00, 1'b0); feed_byte(8'hFF, 1'b0);
    feed_byte(8'h80, 1'b0); feed_byte(8'h7F, 1'b0);
    feed_byte(8'(pus_pkg::FILT_SUB), 1'b0);
    feed_byte(8'h01, 1'b0); feed_byte(8'hFF, 1'b0);
    feed_byte(8'h00, 1'b0); feed_byte(8'h80, 1'b0);
    feed_byte(8'(pus_pkg::FILT_UP), 1'b0);
    feed_byte(8'hFF, 1'b0); feed_byte(8'h01, 1'b0);
    feed_byte(8'h80, 1'b0); feed_byte(8'h00, 1'b0);
    feed_byte(8'(pus_pkg::FILT_AVG), 1'b0);
    feed_byte(8'h00, 1'b0); feed_byte(8'hFF, 1'b0);
    feed_byte(8'hFF, 1'b0); feed_byte(8'h01, 1'b0);
    feed_byte(8'(pus_pkg::FILT_PAETH), 1'b0);
    feed_byte(8'h10, 1'b0); feed_byte(8'hF0, 1'b0);
    feed_byte(8'h00, 1'b0); feed_byte(8'hFF, 1'b0);
  endtask

  task automatic test_bad_filter();
    feed_byte(8'(int'(pus_pkg::FILT_PAETH) + 1), 1'b1);
    feed_byte(8'(pus_pkg::FILT_NONE), 1'b0);
    feed_byte(8'h33, 1'b0);
    feed_byte(8'hFF, 1'b1);
    feed_byte(8'(pus_pkg::FILT_UP), 1'b1);
    feed_random_bytes(4);
    feed_byte(8'h80, 1'b0);
    feed_byte(8'h00, 1'b0);
  endtask

  task automatic test_restart_mid_row();
    feed_byte(8'(pus_pkg::FILT_SUB), 1'b1);
    feed_random_bytes(2);
    feed_byte(8'(pus_pkg::FILT_AVG), 1'b1);
    feed_random_bytes(4);
    feed_byte(8'(pus_pkg::FILT_PAETH), 1'b0);
    feed_random_bytes(4);
  endtask

  task automatic test_register_clamps();
    wait_idle();
    set_config(15'd0, 15'd0, 1'b0);
    feed_byte(8'(pus_pkg::FILT_PAETH), 1'b1);
    feed_byte(8'h7F, 1'b0);
    feed_byte(8'(pus_pkg::FILT_SUB), 1'b0);
    feed_byte(8'h80, 1'b0);
    wait_idle();
    set_config(15'h000F, 15'd10, 1'b1);
    feed_byte(8'(pus_pkg::FILT_SUB), 1'b1);
    feed_random_bytes(10);
    feed_byte(8'(pus_pkg::FILT_PAETH), 1'b0);
    feed_random_bytes(10);
  endtask

  task automatic test_mid_row_config();
    wait_idle();
    set_config(15'd2, 15'd6, 1'b0);
    feed_byte(8'(pus_pkg::FILT_UP), 1'b1);
    feed_random_bytes(6);
    feed_byte(8'(pus_pkg::FILT_AVG), 1'b0);
    feed_random_bytes(3);
    wait_idle();
    set_config(15'd3, 15'd4, 1'b0);
    feed_random_bytes(1);
    feed_byte(8'(pus_pkg::FILT_SUB), 1'b0);
    feed_random_bytes(3);
    wait_idle();
    set_config(15'd3, 15'd2, 1'b0);
    feed_random_bytes(1);
  endtask

  task automatic test_wide_row();
    wait_idle();
    gap_max   = 0;
    rx_stalls = 1'b0;
    set_config(15'h7FFF, 15'h7FFF, 1'b0);
    feed_byte(8'(pus_pkg::FILT_PAETH), 1'b1);
    feed_random_bytes(150);
  endtask

  task automatic test_random_images();
    int target;
    int rows;
    target = work_items + 1300;
    while (work_items < target) begin
      wait_idle();
      gap_max   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      rx_stalls = $urandom_range(0, 3) != 0;
      set_config(pick_bpp_word(), pick_rb_word(), $urandom_range(0, 7) == 0);
      rows = $urandom_range(1, 6);
      feed_byte(pick_filter(), 1'b1);
      for (int n = 0; n < rows && !stopped; n++) begin
        if (n > 0) feed_byte(pick_filter(), $urandom_range(0, 49) == 0);
        while (col_cnt != 0 && !stopped) begin
          if ($urandom_range(0, 299) == 0) begin
            wait_idle();
            set_config(pick_bpp_word(), pick_rb_word(), 1'b0);
          end
          feed_byte(pick_data(), $urandom_range(0, 199) == 0);
        end
      end
      if (stopped) begin
        repeat ($urandom_range(1, 4)) feed_byte(8'($urandom), 1'b0);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_every_filter();
    test_bad_filter();
    test_restart_mid_row();
    test_register_clamps();
    test_mid_row_config();
    test_wide_row();
    test_random_images();
    wait_idle();
    repeat (20) @(posedge clk);
    if (miss_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: png_scanline_unfilter_core.f
+incdir+rtl/core
rtl/core/pus_pkg.sv
rtl/core/pus_ram.sv
rtl/core/pus_front.sv
rtl/core/pus_queue.sv
rtl/core/pus_back.sv
rtl/core/png_scanline_unfilter_core.sv
rtl/core/pus_checker.sv
test/tb_png_scanline_unfilter_core.sv
